[hw/rtl/per_client_fixed_window_rate_limiter_macros.svh]
// Assertion macros used by the rate limiter checker.
`ifndef PER_CLIENT_FIXED_WINDOW_RATE_LIMITER_MACROS_SVH
`define PER_CLIENT_FIXED_WINDOW_RATE_LIMITER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCFWRL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PCFWRL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/pcfwrl_pkg.sv]
// Shared types and constants of the per-client fixed-window rate limiter.
package pcfwrl_pkg;

	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 16;
	localparam int COUNT_W     = 16;
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 24;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_REQUESTS_PER_WINDOW = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECONDS      = 4'd1;

	localparam logic [CFG_DATA_W-1:0] RESET_REQUESTS_PER_WINDOW = 16'd60;
	localparam logic [CFG_DATA_W-1:0] RESET_WINDOW_SECONDS      = 16'd60;
	localparam logic [COUNT_W-1:0]    COUNT_MAX                 = 16'hFFFF;

	// One table entry as stored in the entry memory
	typedef struct packed {
		logic [31:0]        peer_ip;
		logic [COUNT_W-1:0] request_count;
		logic [31:0]        win_begin;
	} entry_t;

	// Memory port strobes
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} ram_ctrl_t;

	// One result item
	typedef struct packed {
		logic               table_cleared;
		logic               new_client;
		logic [COUNT_W-1:0] request_count;
		logic               limited;
	} result_t;

endpackage

[hw/rtl/pcfwrl_entry_ram.sv]
// Entry memory: one write port, one read port, registered read data.
module pcfwrl_entry_ram #(
	parameter int DEPTH = 256,
	parameter int IDX_W = 8
) (
	input  logic                  clk,
	input  pcfwrl_pkg::ram_ctrl_t ctrl,
	input  logic [IDX_W-1:0]      rd_idx,
	input  logic [IDX_W-1:0]      wr_idx,
	input  pcfwrl_pkg::entry_t    wr_entry,
	output pcfwrl_pkg::entry_t    rd_entry
);
	import pcfwrl_pkg::*;

	entry_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[wr_idx] <= wr_entry;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rd_entry <= mem[rd_idx];
		end
	end

endmodule

[hw/rtl/pcfwrl_ctrl.sv]
// Lookup sequencer: scans the entry memory, updates the window count, builds the result.
module pcfwrl_ctrl #(
	parameter int MAX_CLIENTS = 256,
	parameter int IDX_W       = 8,
	parameter int OCC_W       = 9
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// request side
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  address_valid,
	input  logic [31:0]                           peer_ip,
	input  logic [31:0]                           now_seconds,
	// configuration
	input  logic [pcfwrl_pkg::CFG_DATA_W-1:0]     requests_per_window,
	input  logic [pcfwrl_pkg::CFG_DATA_W-1:0]     window_seconds,
	// entry memory
	output pcfwrl_pkg::ram_ctrl_t                 ram_ctrl,
	output logic [IDX_W-1:0]                      rd_idx,
	output logic [IDX_W-1:0]                      wr_idx,
	output pcfwrl_pkg::entry_t                    wr_entry,
	input  pcfwrl_pkg::entry_t                    rd_entry,
	// result side
	output logic                                  res_valid,
	input  logic                                  res_ready,
	output pcfwrl_pkg::result_t                   res
);
	import pcfwrl_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_EVAL   = 5'b00100,
		ST_COMMIT = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	state_t             state_q;
	logic [31:0]        addr_q;
	logic [31:0]        now_q;
	logic [OCC_W-1:0]   issue_q;
	logic [OCC_W-1:0]   occ_q;
	logic               valid_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               hit_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic [COUNT_W-1:0] count_q;
	logic [31:0]        start_q;
	logic               expired_q;
	result_t            res_q;

	logic               rd_more;
	logic               hit_now;
	logic               table_full;
	logic [COUNT_W-1:0] new_count;
	logic [31:0]        new_start;

	// Valid entries always sit in slots 0 .. occupancy-1: inserts take the first
	// free slot and only a full clear frees anything.
	assign rd_more    = (issue_q < occ_q);
	assign hit_now    = valid_s1 && (rd_entry.peer_ip == addr_q);
	assign table_full = (occ_q == OCC_W'(MAX_CLIENTS));

	// updated count and window start
	always_comb begin
		if (expired_q) begin
			new_count = COUNT_W'(1);
			new_start = now_q;
		end else begin
			new_count = (count_q == COUNT_MAX) ? COUNT_MAX : count_q + COUNT_W'(1);
			new_start = start_q;
		end
	end

	// memory access
	always_comb begin
		ram_ctrl.rd_en         = (state_q == ST_SCAN) && rd_more;
		ram_ctrl.wr_en         = (state_q == ST_COMMIT) && (hit_q || !table_full);
		rd_idx                 = issue_q[IDX_W-1:0];
		wr_idx                 = hit_q ? hit_idx_q : occ_q[IDX_W-1:0];
		wr_entry.peer_ip       = addr_q;
		wr_entry.request_count = new_count;
		wr_entry.win_begin     = new_start;
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			occ_q    <= '0;
			valid_s1 <= 1'b0;
			issue_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					valid_s1 <= 1'b0;
					issue_q  <= '0;
					if (in_valid) begin
						state_q <= address_valid ? ST_SCAN : ST_DONE;
					end
				end
				ST_SCAN: begin
					valid_s1 <= rd_more;
					if (rd_more) begin
						issue_q <= issue_q + OCC_W'(1);
					end
					if (hit_now || (!valid_s1 && !rd_more)) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (!hit_q) begin
						occ_q <= table_full ? '0 : occ_q + OCC_W'(1);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request payload and scan datapath
	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx;
		if (state_q == ST_IDLE && in_valid) begin
			addr_q <= peer_ip;
			now_q  <= now_seconds;
			res_q  <= '0;
		end
		// first matching entry wins; a scan that runs dry is a miss
		if (state_q == ST_SCAN) begin
			if (hit_now) begin
				hit_q     <= 1'b1;
				hit_idx_q <= idx_s1;
				count_q   <= rd_entry.request_count;
				start_q   <= rd_entry.win_begin;
			end else if (!valid_s1 && !rd_more) begin
				hit_q     <= 1'b0;
				hit_idx_q <= '0;
				count_q   <= '0;
				start_q   <= now_q;
			end
		end
		// window expiry, elapsed time modulo 2^32
		if (state_q == ST_EVAL) begin
			expired_q <= ((now_q - start_q) >= {16'b0, window_seconds});
		end
		if (state_q == ST_COMMIT) begin
			res_q.limited       <= (new_count > requests_per_window);
			res_q.request_count <= new_count;
			res_q.new_client    <= !hit_q;
			res_q.table_cleared <= !hit_q && table_full;
		end
	end

endmodule

[hw/rtl/per_client_fixed_window_rate_limiter.sv]
// Top level of the per-client fixed-window rate limiter.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata[31:0] peer_ip, [63:32] now_seconds;
//                                   tuser address_valid
//  m_*      out  m_tvalid/m_tready  tdata[0] limited, [16:1] request_count,
//                                   [17] new_client, [18] table_cleared
//  cfg_*    in   cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// A request with an address scans the entry memory linearly, one read a cycle,
// over the occupancy filled slots, at most MAX_CLIENTS; a hit stops the scan early.
// Both a hit and a miss then pass through the evaluate and commit states to the
// result, and the next request is taken once the sequencer is back in idle.
// A request without an address skips the scan and goes straight to the result.
// Reset empties the table at once by clearing the fill count; no clearing pass.
// The result waits in an output register, so a stalled m_tready only holds the
// sequencer once its next result is ready. Configuration writes are always taken.
module per_client_fixed_window_rate_limiter #(
	parameter int MAX_CLIENTS = 256
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// request stream
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [pcfwrl_pkg::IN_TDATA_W-1:0]      s_tdata,  // peer_ip, now_seconds
	input  logic                                   s_tuser,  // address_valid
	// result stream
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [pcfwrl_pkg::OUT_TDATA_W-1:0]     m_tdata,  // limited, request_count,
	                                                         // new_client, table_cleared
	// configuration writes
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [pcfwrl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pcfwrl_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import pcfwrl_pkg::*;

	localparam int IDX_W = $clog2(MAX_CLIENTS);
	localparam int OCC_W = $clog2(MAX_CLIENTS + 1);

	logic [CFG_DATA_W-1:0]  requests_per_window_q;
	logic [CFG_DATA_W-1:0]  window_seconds_q;
	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	ram_ctrl_t        ram_ctrl;
	logic [IDX_W-1:0] rd_idx;
	logic [IDX_W-1:0] wr_idx;
	entry_t           wr_entry;
	entry_t           rd_entry;
	logic             res_valid;
	logic             res_ready;
	result_t          res;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			requests_per_window_q <= RESET_REQUESTS_PER_WINDOW;
			window_seconds_q      <= RESET_WINDOW_SECONDS;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_REQUESTS_PER_WINDOW: requests_per_window_q <= cfg_data;
				REG_WINDOW_SECONDS:      window_seconds_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	pcfwrl_ctrl #(
		.MAX_CLIENTS (MAX_CLIENTS),
		.IDX_W       (IDX_W),
		.OCC_W       (OCC_W)
	) u_ctrl (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (s_tvalid),
		.in_ready            (s_tready),
		.address_valid       (s_tuser),
		.peer_ip             (s_tdata[31:0]),
		.now_seconds         (s_tdata[63:32]),
		.requests_per_window (requests_per_window_q),
		.window_seconds      (window_seconds_q),
		.ram_ctrl            (ram_ctrl),
		.rd_idx              (rd_idx),
		.wr_idx              (wr_idx),
		.wr_entry            (wr_entry),
		.rd_entry            (rd_entry),
		.res_valid           (res_valid),
		.res_ready           (res_ready),
		.res                 (res)
	);

	pcfwrl_entry_ram #(
		.DEPTH (MAX_CLIENTS),
		.IDX_W (IDX_W)
	) u_ram (
		.clk      (clk),
		.ctrl     (ram_ctrl),
		.rd_idx   (rd_idx),
		.wr_idx   (wr_idx),
		.wr_entry (wr_entry),
		.rd_entry (rd_entry)
	);

	// output register
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_data_q <= {5'b0, res.table_cleared, res.new_client,
				res.request_count, res.limited};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

[hw/rtl/pcfwrl_checker.sv]
// Port-level checker for the rate limiter, bound to the top level.
`include "per_client_fixed_window_rate_limiter_macros.svh"

module pcfwrl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// a stalled result holds
	`PCFWRL_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// one request at a time: ready drops after each transfer
	`PCFWRL_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready, "request taken while busy")

	// only an insert can clear the table
	`PCFWRL_ASSERT_NOW(a_clear_on_insert, clk, arst_n, m_tvalid && m_tdata[18], m_tdata[17], "table cleared without a new client")

	// a new client starts its window at one request
	`PCFWRL_ASSERT_NOW(a_new_count_one, clk, arst_n, m_tvalid && m_tdata[17], m_tdata[16:1] == 16'd1, "new client count is not one")

endmodule

bind per_client_fixed_window_rate_limiter pcfwrl_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
